@@ hdl/qte_pkg.sv @@
// Shared types, constants and helper functions for the quaternion to Euler angle block.
// Depends on nothing; every other file of the block imports it.
package qte_pkg;

  localparam int QUAT_BITS_DEF     = 16;
  localparam int ANGLE_BITS_DEF    = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  // CORDIC datapath width, square root width and step counts
  localparam int CW         = 64;
  localparam int SQ_W       = 62;
  localparam int SQ_STEPS   = 31;
  localparam int NORM_STEPS = 6;
  localparam int ANG_W      = 32;

  localparam logic [ANG_W-1:0] RIGHT_ANGLE = 32'h4000_0000;

  // One vectoring lane: vector, accumulated angle, and a flag for a finished angle
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [ANG_W-1:0]     ang;
    logic                 done;
  } vec_t;

  // Everything one sample carries down the cell chains
  typedef struct packed {
    logic pose;
    logic sat;
    vec_t roll;
    vec_t pitch;
    vec_t yaw;
  } beat_t;

  // Square root state: remainder and partial root
  typedef struct packed {
    logic [SQ_W-1:0] v;
    logic [SQ_W-1:0] r;
  } sqst_t;

  localparam logic [ANG_W-1:0] ARC_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  function automatic logic [ANG_W-1:0] arc_at(input logic [4:0] i);
    return ARC_TAB[i];
  endfunction

  function automatic logic [CW-1:0] vmag(input logic signed [CW-1:0] v);
    return v[CW-1] ? CW'(-v) : CW'(v);
  endfunction

endpackage

@@ hdl/qte_sqrt_cell.sv @@
// One bit of the pipelined integer square root; the rest of the beat rides along.
// Depends on qte_pkg.
module qte_sqrt_cell import qte_pkg::*; #(
  parameter int BIT_POS = 60
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  vld_i,
  input  beat_t beat_i,
  input  sqst_t sq_i,
  output logic  vld_o,
  output beat_t beat_o,
  output sqst_t sq_o
);

  localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << BIT_POS;

  logic            vld_q;
  beat_t           beat_q;
  sqst_t           sq_d, sq_q;
  logic [SQ_W-1:0] trial;

  always_comb begin
    trial = sq_i.r + BIT;
    if (sq_i.v >= trial) begin
      sq_d.v = sq_i.v - trial;
      sq_d.r = (sq_i.r >> 1) + BIT;
    end else begin
      sq_d.v = sq_i.v;
      sq_d.r = sq_i.r >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    beat_q <= beat_i;
    sq_q   <= sq_d;
  end

  assign vld_o  = vld_q;
  assign beat_o = beat_q;
  assign sq_o   = sq_q;

endmodule

@@ hdl/qte_norm_cell.sv @@
// One step of the normalizing shift for all three lanes: shift left by SH while the
// larger magnitude stays below 2^59. Depends on qte_pkg.
module qte_norm_cell import qte_pkg::*; #(
  parameter int SH = 32
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  vld_i,
  input  beat_t beat_i,
  output logic  vld_o,
  output beat_t beat_o
);

  localparam logic [CW-1:0] LIMIT = CW'(1) << (59 - SH);

  logic  vld_q;
  beat_t beat_d, beat_q;

  function automatic vec_t norm_lane(input vec_t v);
    vec_t          o;
    logic [CW-1:0] m;
    o = v;
    m = vmag(v.x) | vmag(v.y);
    if (!v.done && (m < LIMIT)) begin
      o.x = v.x <<< SH;
      o.y = v.y <<< SH;
    end
    return o;
  endfunction

  always_comb begin
    beat_d       = beat_i;
    beat_d.roll  = norm_lane(beat_i.roll);
    beat_d.pitch = norm_lane(beat_i.pitch);
    beat_d.yaw   = norm_lane(beat_i.yaw);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    beat_q <= beat_d;
  end

  assign vld_o  = vld_q;
  assign beat_o = beat_q;

endmodule

@@ hdl/qte_cordic_cell.sv @@
// One vectoring CORDIC iteration for all three lanes; finished lanes pass unchanged.
// Depends on qte_pkg.
module qte_cordic_cell import qte_pkg::*; #(
  parameter int I = 0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  vld_i,
  input  beat_t beat_i,
  output logic  vld_o,
  output beat_t beat_o
);

  localparam logic [ANG_W-1:0] ARC = arc_at(5'(I));

  logic  vld_q;
  beat_t beat_d, beat_q;

  function automatic vec_t rot_lane(input vec_t v);
    vec_t                 o;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    o  = v;
    dx = v.x >>> I;
    dy = v.y >>> I;
    if (!v.done) begin
      if (v.y > 0) begin
        o.x   = v.x + dy;
        o.y   = v.y - dx;
        o.ang = v.ang + ARC;
      end else begin
        o.x   = v.x - dy;
        o.y   = v.y + dx;
        o.ang = v.ang - ARC;
      end
    end
    return o;
  endfunction

  always_comb begin
    beat_d       = beat_i;
    beat_d.roll  = rot_lane(beat_i.roll);
    beat_d.pitch = rot_lane(beat_i.pitch);
    beat_d.yaw   = rot_lane(beat_i.yaw);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    beat_q <= beat_d;
  end

  assign vld_o  = vld_q;
  assign beat_o = beat_q;

endmodule

@@ hdl/quaternion_to_euler_angles.sv @@
// Top level: quaternion to roll, pitch and yaw, one sample per clock.
// Depends on qte_pkg, qte_sqrt_cell, qte_norm_cell and qte_cordic_cell.
//
//  Channel  | Handshake         | Payload
//  ---------+-------------------+------------------------------------------------
//  sample   | start_i / busy_o  | quat_w_i, quat_x_i, quat_y_i, quat_z_i, pose_valid_i
//  result   | done_o (strobe)   | roll_angle_o, pitch_angle_o, yaw_angle_o,
//           |                   | result_valid_o, pitch_saturated_o
//
// Cycles: a beat is taken at every edge with start_i high; busy_o stays low.
// A sample passes through the pipeline: 4 front stages (capture, products, sums,
// square), 31 square root cells, 1 quadrant stage, 6 normalizing cells,
// CORDIC_STAGES rotation cells and the output register. Reset clears only
// the valid bits of the pipeline. The receiver cannot stall: each result shows
// for exactly one cycle.
module quaternion_to_euler_angles import qte_pkg::*; #(
  parameter int QUAT_BITS     = QUAT_BITS_DEF,
  parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic signed [QUAT_BITS-1:0]  quat_w_i,
  input  logic signed [QUAT_BITS-1:0]  quat_x_i,
  input  logic signed [QUAT_BITS-1:0]  quat_y_i,
  input  logic signed [QUAT_BITS-1:0]  quat_z_i,
  input  logic                         pose_valid_i,
  output logic                         done_o,
  output logic signed [ANGLE_BITS-1:0] roll_angle_o,
  output logic signed [ANGLE_BITS-1:0] pitch_angle_o,
  output logic signed [ANGLE_BITS-1:0] yaw_angle_o,
  output logic                         result_valid_o,
  output logic                         pitch_saturated_o
);

  // Working width: components above 24 bits drop their low bits (floor)
  localparam int WB     = (QUAT_BITS > 24) ? 24 : QUAT_BITS;
  localparam int WF     = WB - 1;
  localparam int FR2    = 2 * WF;
  localparam int RND_SH = ANG_W - ANGLE_BITS;
  localparam int PW     = 2 * WB;

  localparam logic signed [CW-1:0]   ONE      = CW'(1) <<< FR2;
  localparam logic [SQ_W-1:0]        SQ_ONE   = SQ_W'(1) << 60;
  localparam logic signed [ANG_W-1:0] ANG_POS = RIGHT_ANGLE;
  localparam logic signed [ANG_W-1:0] ANG_NEG = -RIGHT_ANGLE;
  localparam int PITCH_MAX = 2 ** (ANGLE_BITS - 2);

  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // ---------------------------------------------------------------- capture stage
  logic                 v0_q;
  logic signed [WB-1:0] w_q, x_q, y_q, z_q;
  logic                 pose0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      w_q     <= quat_w_i[QUAT_BITS-1 -: WB];
      x_q     <= quat_x_i[QUAT_BITS-1 -: WB];
      y_q     <= quat_y_i[QUAT_BITS-1 -: WB];
      z_q     <= quat_z_i[QUAT_BITS-1 -: WB];
      pose0_q <= pose_valid_i;
    end
  end

  // ---------------------------------------------------------------- product stage
  logic                 v1_q, pose1_q;
  logic signed [PW-1:0] p_wx_q, p_yz_q, p_xx_q, p_yy_q, p_zz_q;
  logic signed [PW-1:0] p_wz_q, p_xy_q, p_wy_q, p_xz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pose1_q <= pose0_q;
    p_wx_q  <= w_q * x_q;
    p_yz_q  <= y_q * z_q;
    p_xx_q  <= x_q * x_q;
    p_yy_q  <= y_q * y_q;
    p_zz_q  <= z_q * z_q;
    p_wz_q  <= w_q * z_q;
    p_xy_q  <= x_q * y_q;
    p_wy_q  <= w_q * y_q;
    p_xz_q  <= x_q * z_q;
  end

  // ---------------------------------------------------------------- sum stage
  logic                 v2_q, pose2_q, sat2_q;
  logic signed [CW-1:0] rx_q, ry_q, yx_q, yy_q, s30_q;
  logic signed [CW-1:0] rx_c, ry_c, yx_c, yy_c, s_raw, s_cl, s30_c;
  logic                 sat_c;

  always_comb begin
    rx_c  = ONE - ((CW'(p_xx_q) + CW'(p_yy_q)) <<< 1);
    ry_c  = (CW'(p_wx_q) + CW'(p_yz_q)) <<< 1;
    yx_c  = ONE - ((CW'(p_yy_q) + CW'(p_zz_q)) <<< 1);
    yy_c  = (CW'(p_wz_q) + CW'(p_xy_q)) <<< 1;
    s_raw = (CW'(p_wy_q) - CW'(p_xz_q)) <<< 1;
    // clamp the asin argument to plus or minus one
    sat_c = 1'b0;
    s_cl  = s_raw;
    if (s_raw > ONE) begin
      s_cl  = ONE;
      sat_c = 1'b1;
    end
    if (s_raw < -ONE) begin
      s_cl  = -ONE;
      sat_c = 1'b1;
    end
  end

  // move the argument to 30 fraction bits
  if (FR2 > 30) begin : g_s30_dn
    assign s30_c = s_cl >>> (FR2 - 30);
  end else begin : g_s30_up
    assign s30_c = s_cl <<< (30 - FR2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pose2_q <= pose1_q;
    sat2_q  <= sat_c;
    rx_q    <= rx_c;
    ry_q    <= ry_c;
    yx_q    <= yx_c;
    yy_q    <= yy_c;
    s30_q   <= s30_c;
  end

  // ---------------------------------------------------------------- square stage
  logic [CW-1:0]   s_abs;
  logic [30:0]     s_mag;
  logic [61:0]     s_sqr;
  logic            v3_q;
  beat_t           beat3_q;
  sqst_t           sq3_q;

  assign s_abs = vmag(s30_q);
  assign s_mag = s_abs[30:0];
  assign s_sqr = s_mag * s_mag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    beat3_q.pose       <= pose2_q;
    beat3_q.sat        <= sat2_q;
    beat3_q.roll       <= '{x: rx_q, y: ry_q, ang: '0, done: 1'b0};
    beat3_q.yaw        <= '{x: yx_q, y: yy_q, ang: '0, done: 1'b0};
    // hold the argument in pitch.y until the root is known
    beat3_q.pitch      <= '{x: '0, y: s30_q, ang: '0, done: 1'b0};
    sq3_q.v            <= SQ_ONE - SQ_W'(s_sqr);
    sq3_q.r            <= '0;
  end

  // ---------------------------------------------------------------- square root chain
  logic  sq_vld  [SQ_STEPS+1];
  beat_t sq_beat [SQ_STEPS+1];
  sqst_t sq_st   [SQ_STEPS+1];

  assign sq_vld[0]  = v3_q;
  assign sq_beat[0] = beat3_q;
  assign sq_st[0]   = sq3_q;

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    qte_sqrt_cell #(
      .BIT_POS(60 - 2 * k)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .vld_i (sq_vld[k]),
      .beat_i(sq_beat[k]),
      .sq_i  (sq_st[k]),
      .vld_o (sq_vld[k+1]),
      .beat_o(sq_beat[k+1]),
      .sq_o  (sq_st[k+1])
    );
  end

  // ---------------------------------------------------------------- quadrant stage
  // Finish zero and vertical vectors at once; fold the left half plane by a quarter turn.
  function automatic vec_t prep_lane(input logic signed [CW-1:0] x,
                                     input logic signed [CW-1:0] y);
    vec_t o;
    o = '{x: x, y: y, ang: '0, done: 1'b0};
    if (x == 0) begin
      o.done = 1'b1;
      if (y == 0) begin
        o.ang = '0;
      end else if (y > 0) begin
        o.ang = ANG_POS;
      end else begin
        o.ang = ANG_NEG;
      end
    end else if (x < 0) begin
      if (y >= 0) begin
        o.x   = y;
        o.y   = -x;
        o.ang = ANG_POS;
      end else begin
        o.x   = -y;
        o.y   = x;
        o.ang = ANG_NEG;
      end
    end
    return o;
  endfunction

  logic  vp_q;
  beat_t beatp_d, beatp_q;

  always_comb begin
    beatp_d       = sq_beat[SQ_STEPS];
    beatp_d.roll  = prep_lane(sq_beat[SQ_STEPS].roll.x, sq_beat[SQ_STEPS].roll.y);
    beatp_d.yaw   = prep_lane(sq_beat[SQ_STEPS].yaw.x, sq_beat[SQ_STEPS].yaw.y);
    beatp_d.pitch = prep_lane(CW'(sq_st[SQ_STEPS].r), sq_beat[SQ_STEPS].pitch.y);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else begin
      vp_q <= sq_vld[SQ_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    beatp_q <= beatp_d;
  end

  // ---------------------------------------------------------------- normalizing chain
  logic  nm_vld  [NORM_STEPS+1];
  beat_t nm_beat [NORM_STEPS+1];

  assign nm_vld[0]  = vp_q;
  assign nm_beat[0] = beatp_q;

  for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
    qte_norm_cell #(
      .SH(1 << (NORM_STEPS - 1 - k))
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .vld_i (nm_vld[k]),
      .beat_i(nm_beat[k]),
      .vld_o (nm_vld[k+1]),
      .beat_o(nm_beat[k+1])
    );
  end

  // ---------------------------------------------------------------- rotation chain
  logic  cr_vld  [CORDIC_STAGES+1];
  beat_t cr_beat [CORDIC_STAGES+1];

  assign cr_vld[0]  = nm_vld[NORM_STEPS];
  assign cr_beat[0] = nm_beat[NORM_STEPS];

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    qte_cordic_cell #(
      .I(k)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .vld_i (cr_vld[k]),
      .beat_i(cr_beat[k]),
      .vld_o (cr_vld[k+1]),
      .beat_o(cr_beat[k+1])
    );
  end

  // ---------------------------------------------------------------- output stage
  // Round to ANGLE_BITS: add half an output LSB (wrapping) and drop the low bits.
  function automatic logic [ANGLE_BITS-1:0] to_out(input logic [ANG_W-1:0] a);
    logic [ANG_W-1:0] half;
    logic [ANG_W-1:0] s;
    half = ANG_W'((33'd1 << RND_SH) >> 1);
    s    = a + half;
    return s[ANG_W-1 -: ANGLE_BITS];
  endfunction

  beat_t                   fin;
  logic signed [ANG_W-1:0] pa;
  logic [ANG_W-1:0]        pitch_cl;

  assign fin = cr_beat[CORDIC_STAGES];
  assign pa  = fin.pitch.ang;

  always_comb begin
    pitch_cl = fin.pitch.ang;
    if (pa > ANG_POS) begin
      pitch_cl = ANG_POS;
    end
    if (pa < ANG_NEG) begin
      pitch_cl = ANG_NEG;
    end
  end

  logic                  done_q, rvld_q, sat_q;
  logic [ANGLE_BITS-1:0] roll_q, pitch_q, yaw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cr_vld[CORDIC_STAGES];
    end
  end

  // drop everything to zero when no pose has been set
  always_ff @(posedge clk_i) begin
    if (fin.pose) begin
      roll_q  <= to_out(fin.roll.ang);
      pitch_q <= to_out(pitch_cl);
      yaw_q   <= to_out(fin.yaw.ang);
      rvld_q  <= 1'b1;
      sat_q   <= fin.sat;
    end else begin
      roll_q  <= '0;
      pitch_q <= '0;
      yaw_q   <= '0;
      rvld_q  <= 1'b0;
      sat_q   <= 1'b0;
    end
  end

  assign done_o            = done_q;
  assign roll_angle_o      = roll_q;
  assign pitch_angle_o     = pitch_q;
  assign yaw_angle_o       = yaw_q;
  assign result_valid_o    = rvld_q;
  assign pitch_saturated_o = sat_q;

  // ---------------------------------------------------------------- assertions
  a_invalid_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_valid_o) |-> (roll_angle_o == '0 && pitch_angle_o == '0 &&
                                     yaw_angle_o == '0 && !pitch_saturated_o))
    else $error("invalid result carries nonzero fields");

  a_pitch_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($signed(pitch_angle_o) <= PITCH_MAX &&
                $signed(pitch_angle_o) >= -PITCH_MAX))
    else $error("pitch outside plus or minus a quarter turn");

  a_root_x_nonneg : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vp_q |-> (!beatp_q.pitch.x[CW-1]))
    else $error("pitch vector has negative x after quadrant fold");

endmodule
